/* hdl/tla_pkg.sv */
// Shared types and character constants for the text line annotator.
`default_nettype none
package tla_pkg;

	// Mode bits, one per configuration register.
	typedef struct packed {
		logic show_nonprinting;
		logic show_tabs;
		logic show_ends;
		logic squeeze_blank;
		logic number_nonblank;
		logic number_all;
	} cfg_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_NUMBER_ALL       = 3'd0,
		REG_NUMBER_NONBLANK  = 3'd1,
		REG_SQUEEZE_BLANK    = 3'd2,
		REG_SHOW_ENDS        = 3'd3,
		REG_SHOW_TABS        = 3'd4,
		REG_SHOW_NONPRINTING = 3'd5
	} reg_idx_t;

	localparam int CFG_INDEX_W = 3;
	// Line numbers are right-aligned to at least this many places.
	localparam int NUM_FIELD   = 6;

	localparam logic [7:0] CHR_TAB      = 8'd9;
	localparam logic [7:0] CHR_NL       = 8'd10;
	localparam logic [7:0] CHR_SPACE    = 8'd32;
	localparam logic [7:0] CHR_DOLLAR   = 8'd36;
	localparam logic [7:0] CHR_ZERO     = 8'd48;
	localparam logic [7:0] CHR_QMARK    = 8'd63;
	localparam logic [7:0] CHR_I        = 8'd73;
	localparam logic [7:0] CHR_CARET    = 8'd94;
	localparam logic [7:0] CHR_DEL      = 8'd127;
	localparam logic [7:0] CTRL_LIMIT   = 8'd32;
	localparam logic [7:0] CARET_OFFSET = 8'd64;

endpackage
`default_nettype wire

/* hdl/tla_format.sv */
// Combinational formatter: turns one input byte into a frame of output characters.
`default_nettype none
module tla_format #(
	parameter int COUNT_DIGITS = 7,
	localparam int NW = (COUNT_DIGITS > tla_pkg::NUM_FIELD) ? COUNT_DIGITS : tla_pkg::NUM_FIELD,
	localparam int NS = NW + 3,
	localparam int IW = $clog2(NS)
) (
	input  wire logic [7:0]                  in_byte,
	input  wire logic                        file_start,
	input  wire tla_pkg::cfg_t               cfg,
	input  wire logic [7:0]                  prev,
	input  wire logic [1:0]                  run,
	input  wire logic [4*COUNT_DIGITS-1:0]   num,
	output logic [NS-1:0][7:0]               slots,
	output logic [IW-1:0]                    first_idx,
	output logic [IW-1:0]                    last_idx,
	output logic                             drop,
	output logic [7:0]                       prev_next,
	output logic [1:0]                       run_next,
	output logic [4*COUNT_DIGITS-1:0]        num_next
);
	import tla_pkg::*;

	localparam int SW = $clog2(COUNT_DIGITS + 1);

	logic [7:0]                prev_e;
	logic [1:0]                run_e;
	logic [4*COUNT_DIGITS-1:0] num_e;
	logic [4*COUNT_DIGITS-1:0] num_inc;
	logic                      numbering;
	logic                      all_nines;
	logic [SW-1:0]             sig;
	logic [IW-1:0]             num_len;
	logic [7:0]                tail0;
	logic [7:0]                tail1;
	logic                      tail_two;
	logic [7:0]                main_chr;

	// Start-of-file clears the stream state before the byte is handled.
	always_comb begin
		if (file_start) begin
			prev_e = CHR_NL;
			run_e  = 2'd0;
			num_e  = (4*COUNT_DIGITS)'(1);
		end else begin
			prev_e = prev;
			run_e  = run;
			num_e  = num;
		end
	end

	// Blank-line squeezing.
	always_comb begin
		drop     = 1'b0;
		run_next = 2'd0;
		if (cfg.squeeze_blank && in_byte == CHR_NL && prev_e == CHR_NL) begin
			run_next = (run_e < 2'd2) ? run_e + 2'd1 : run_e;
			drop     = (run_next > 2'd1);
		end
	end

	assign numbering = prev_e == CHR_NL &&
		((cfg.number_all && !cfg.number_nonblank) ||
		 (cfg.number_nonblank && in_byte != CHR_NL));

	// BCD increment; a digit at nine or above wraps to zero and carries.
	always_comb begin
		logic carry;
		carry     = 1'b1;
		all_nines = 1'b1;
		num_inc   = num_e;
		for (int i = 0; i < COUNT_DIGITS; i++) begin
			if (num_e[4*i +: 4] != 4'd9) begin
				all_nines = 1'b0;
			end
			if (carry) begin
				if (num_e[4*i +: 4] >= 4'd9) begin
					num_inc[4*i +: 4] = 4'd0;
				end else begin
					num_inc[4*i +: 4] = num_e[4*i +: 4] + 4'd1;
					carry = 1'b0;
				end
			end
		end
	end

	assign num_next = (!drop && numbering && !all_nines) ? num_inc : num_e;

	// Count of significant digits, at least one.
	always_comb begin
		sig = SW'(1);
		for (int i = 1; i < COUNT_DIGITS; i++) begin
			if (num_e[4*i +: 4] != 4'd0) begin
				sig = SW'(i + 1);
			end
		end
	end

	assign num_len = (IW'(sig) > IW'(NUM_FIELD)) ? IW'(sig) : IW'(NUM_FIELD);

	// Main character and its optional leading marker.
	always_comb begin
		tail_two = 1'b0;
		tail0    = in_byte;
		tail1    = in_byte;
		main_chr = in_byte;
		if (cfg.show_tabs && in_byte == CHR_TAB) begin
			tail_two = 1'b1;
			tail0    = CHR_CARET;
			tail1    = CHR_I;
			main_chr = CHR_I;
		end else if (cfg.show_ends && in_byte == CHR_NL) begin
			tail_two = 1'b1;
			tail0    = CHR_DOLLAR;
			tail1    = CHR_NL;
		end else if (cfg.show_nonprinting && in_byte == CHR_DEL) begin
			tail_two = 1'b1;
			tail0    = CHR_CARET;
			tail1    = CHR_QMARK;
		end else if (cfg.show_nonprinting && (in_byte < CHR_TAB ||
				(in_byte > CHR_NL && in_byte < CTRL_LIMIT))) begin
			tail_two = 1'b1;
			tail0    = CHR_CARET;
			tail1    = in_byte + CARET_OFFSET;
			main_chr = in_byte + CARET_OFFSET;
		end
	end

	assign prev_next = drop ? prev_e : main_chr;

	// Frame layout: the number field right-aligned in the low slots, its tab,
	// then one or two tail characters. The emitter walks first_idx..last_idx.
	always_comb begin
		slots = '0;
		for (int p = 0; p < NW; p++) begin
			if (NW - 1 - p < COUNT_DIGITS && SW'(NW - 1 - p) < sig) begin
				slots[p] = CHR_ZERO + {4'd0, num_e[4*(NW-1-p) +: 4]};
			end else begin
				slots[p] = CHR_SPACE;
			end
		end
		slots[NW]     = CHR_TAB;
		slots[NW + 1] = tail0;
		slots[NW + 2] = tail1;
	end

	assign first_idx = numbering ? IW'(NW) - num_len : IW'(NW + 1);
	assign last_idx  = tail_two ? IW'(NW + 2) : IW'(NW + 1);

endmodule
`default_nettype wire

/* hdl/text_line_annotator.sv */
// Top level of the text line annotator: state, mode registers and output buffering.
`default_nettype none
// Byte filter in the style of cat. Each accepted byte produces between zero
// and max(6, COUNT_DIGITS) + 3 output characters; run_last marks the final
// character of each byte. A byte is formatted in the cycle it is accepted
// and its characters leave one per cycle from the output frame register
// while out_stall is low, so the output port sets the pace. A second frame
// register lets one more byte be accepted while the output is busy or
// stalled; input stalls only while that register is full. A byte dropped by
// blank-line squeezing never enters a frame register. Mode registers take
// effect at once and should be written only while the block is idle.
module text_line_annotator #(
	parameter int COUNT_DIGITS = 7
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [tla_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [0:0]                    cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    in_byte,
	input  wire logic                          file_start,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [7:0]                         out_byte,
	output logic                               run_last
);
	import tla_pkg::*;

	localparam int NW = (COUNT_DIGITS > NUM_FIELD) ? COUNT_DIGITS : NUM_FIELD;
	localparam int NS = NW + 3;
	localparam int IW = $clog2(NS);
	localparam int BW = 4 * COUNT_DIGITS;

	cfg_t              cfg_q;
	logic [7:0]        prev_q;
	logic [1:0]        run_q;
	logic [BW-1:0]     num_q;

	logic [NS-1:0][7:0] f_slots;
	logic [IW-1:0]      f_first;
	logic [IW-1:0]      f_last;
	logic               f_drop;
	logic [7:0]         f_prev;
	logic [1:0]         f_run;
	logic [BW-1:0]      f_num;

	logic               valid_s1;
	logic [NS-1:0][7:0] slots_s1;
	logic [IW-1:0]      first_s1;
	logic [IW-1:0]      last_s1;

	logic               valid_s2;
	logic [NS-1:0][7:0] slots_s2;
	logic [IW-1:0]      idx_s2;
	logic [IW-1:0]      last_s2;

	logic in_xfer;
	logic emit;
	logic out_xfer;
	logic out_done;
	logic s2_free;

	tla_format #(
		.COUNT_DIGITS(COUNT_DIGITS)
	) u_format (
		.in_byte   (in_byte),
		.file_start(file_start),
		.cfg       (cfg_q),
		.prev      (prev_q),
		.run       (run_q),
		.num       (num_q),
		.slots     (f_slots),
		.first_idx (f_first),
		.last_idx  (f_last),
		.drop      (f_drop),
		.prev_next (f_prev),
		.run_next  (f_run),
		.num_next  (f_num)
	);

	assign in_stall  = valid_s1;
	assign in_xfer   = in_valid && !in_stall;
	assign emit      = in_xfer && !f_drop;
	assign out_xfer  = valid_s2 && !out_stall;
	assign out_done  = out_xfer && (idx_s2 == last_s2);
	assign s2_free   = !valid_s2 || out_done;

	assign out_valid = valid_s2;
	assign out_byte  = slots_s2[idx_s2];
	assign run_last  = (idx_s2 == last_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUMBER_ALL:       cfg_q.number_all       <= cfg_data[0];
				REG_NUMBER_NONBLANK:  cfg_q.number_nonblank  <= cfg_data[0];
				REG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_data[0];
				REG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_data[0];
				REG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_data[0];
				REG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= CHR_NL;
			run_q  <= 2'd0;
			num_q  <= BW'(1);
		end else if (in_xfer) begin
			prev_q <= f_prev;
			run_q  <= f_run;
			num_q  <= f_num;
		end
	end

	// Frame valid flags. The output frame refills from the skid frame first;
	// the input is stalled whenever the skid frame holds something.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s2_free) begin
				valid_s2 <= valid_s1 || emit;
				valid_s1 <= 1'b0;
			end else if (emit) begin
				valid_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_s2 <= '0;
		end else if (s2_free) begin
			idx_s2 <= valid_s1 ? first_s1 : f_first;
		end else if (out_xfer) begin
			idx_s2 <= IW'(idx_s2 + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			slots_s2 <= valid_s1 ? slots_s1 : f_slots;
			last_s2  <= valid_s1 ? last_s1 : f_last;
		end
		if (!s2_free && emit) begin
			slots_s1 <= f_slots;
			first_s1 <= f_first;
			last_s1  <= f_last;
		end
	end

endmodule
`default_nettype wire
